>>> src/arle_pkg.sv
// Shared types and constants for the animation RLE decoder.
// Used by arle_step and animation_rle_decoder_top; depends on nothing else.
package arle_pkg;

   // Parse phases, one-hot.
   typedef enum logic [8:0] {
      PH_SIZE  = 9'b000000001,
      PH_FLAGS = 9'b000000010,
      PH_LINE  = 9'b000000100,
      PH_PAD   = 9'b000001000,
      PH_SKIP  = 9'b000010000,
      PH_CODE  = 9'b000100000,
      PH_LIT   = 9'b001000000,
      PH_RUN   = 9'b010000000,
      PH_IDLE  = 9'b100000000
   } phase_type;

   localparam logic [3:0]  SIZE_BYTES      = 4'd4;
   localparam logic [3:0]  FLAG_BYTES      = 4'd2;
   localparam logic [3:0]  LINE_BYTES      = 4'd2;
   localparam logic [3:0]  PAD_BYTES       = 4'd6;
   localparam logic [15:0] START_LINE_FLAG = 16'h0008;
   localparam logic [7:0]  CODE_NEW_SKIP   = 8'h00;
   localparam logic [7:0]  CODE_NEXT_LINE  = 8'hFF;
   localparam logic [2:0]  DEPTH_8         = 3'd0;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [15:0] pix_x;
      logic [15:0] pix_y;
      logic [31:0] pixel_word;
      logic [2:0]  unit_width;
      logic [6:0]  repeat_count;
      logic        frame_done;
      logic        depth_error;
   } rsp_type;

   typedef struct packed {
      phase_type   phase;
      logic [3:0]  header_byte_count;
      logic [15:0] header_flags;
      logic [15:0] cur_x;
      logic [15:0] cur_y;
      logic [6:0]  units_left;
      logic [1:0]  byte_in_unit;
      logic [31:0] unit_accum;
   } state_type;

   localparam state_type STATE_CLEAR = '{
      phase:             PH_SIZE,
      header_byte_count: 4'd0,
      header_flags:      16'd0,
      cur_x:             16'd0,
      cur_y:             16'd0,
      units_left:        7'd0,
      byte_in_unit:      2'd0,
      unit_accum:        32'd0
   };

   // Bytes in one pixel unit for the two low bits of the depth mode.
   function automatic logic [2:0] unit_bytes(input logic [1:0] depth_low);
      logic [2:0] nbytes;
      case (depth_low)
         2'd1:    nbytes = 3'd2;
         2'd2:    nbytes = 3'd3;
         default: nbytes = 3'd4;
      endcase
      return nbytes;
   endfunction

endpackage

>>> src/animation_rle_decoder_top.sv
// Top level of the animation RLE decoder: state and result registers, handshakes.
// Depends on arle_pkg and arle_step.
//
// The decoder takes one byte of a run-length coded animation chunk per transfer and
// can accept a byte on every clock cycle while no result waits untaken. Each byte
// is parsed in the cycle it is accepted: the parse state register is updated at
// that edge, and the result it causes, if any, is loaded into a one-entry output
// register, so rsp_valid rises in the cycle after the byte that completes a pixel
// unit, ends the frame, or finds an unsupported depth. A new byte is taken while a
// result waits, provided the result is taken in the same cycle. Write the depth
// register only while no result is pending; the write takes effect for the next byte.
module animation_rle_decoder_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  arle_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output arle_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_data
);

   arle_pkg::state_type state_ff;
   arle_pkg::state_type state_in;
   arle_pkg::rsp_type   rsp_data_ff;
   arle_pkg::rsp_type   step_res;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                step_valid;
   logic [2:0]          depth_mode_ff;
   logic                req_fire;

   arle_step u_step (
      .state_cur  (state_ff),
      .req        (req_data),
      .depth_mode (depth_mode_ff),
      .state_nxt  (state_in),
      .res_valid  (step_valid),
      .res        (step_res)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = step_valid;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= arle_pkg::STATE_CLEAR;
         rsp_valid_ff  <= 1'b0;
         depth_mode_ff <= 3'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            state_ff <= state_in;
         end
         if (csr_valid && csr_ready) begin
            depth_mode_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && step_valid) begin
         rsp_data_ff <= step_res;
      end
   end

   // A byte taken after the frame has ended or failed yields nothing.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && !req_data.frame_start && state_ff.phase == arle_pkg::PH_IDLE)
      |=> !rsp_valid_ff)
      else $error("result produced by a byte in the idle phase");

   // A pending end-of-frame or depth error result leaves the parser idle.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.frame_done || rsp_data_ff.depth_error))
      |-> state_ff.phase == arle_pkg::PH_IDLE)
      else $error("parser not idle after frame end or depth error");

   // A pixel span carries no status flags.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.unit_width != 3'd0)
      |-> (!rsp_data_ff.frame_done && !rsp_data_ff.depth_error))
      else $error("pixel span flagged as frame end or error");

endmodule

>>> src/arle_step.sv
// One byte of the parse: next decoder state and the result, if any, for one byte.
// Depends on arle_pkg.
module arle_step (
   input  arle_pkg::state_type state_cur,
   input  arle_pkg::req_type   req,
   input  logic [2:0]          depth_mode,
   output arle_pkg::state_type state_nxt,
   output logic                res_valid,
   output arle_pkg::rsp_type   res
);

   arle_pkg::state_type work;
   logic [2:0]  upx;
   logic [3:0]  cnt_inc;
   logic [7:0]  b;
   logic [7:0]  b_minus1;
   logic [7:0]  run_len;
   logic [15:0] skip_adv;
   logic [15:0] run_adv;
   logic [15:0] flags_new;
   logic [31:0] accum_new;
   logic [6:0]  lit_left;

   always_comb begin
      b         = req.data_byte;
      // A marked byte restarts the chunk and is then parsed as its first byte.
      work      = req.frame_start ? arle_pkg::STATE_CLEAR : state_cur;
      upx       = (depth_mode == arle_pkg::DEPTH_8) ? 3'd4 : 3'd1;
      cnt_inc   = work.header_byte_count + 4'd1;
      b_minus1  = b - 8'd1;
      skip_adv  = (depth_mode == arle_pkg::DEPTH_8) ? {6'd0, b_minus1, 2'b00}
                                                     : {8'd0, b_minus1};
      run_len   = (work.units_left == 7'd0) ? 8'd128 : {1'b0, work.units_left};
      run_adv   = (depth_mode == arle_pkg::DEPTH_8) ? {6'd0, run_len, 2'b00}
                                                     : {8'd0, run_len};
      flags_new = {work.header_flags[7:0], b};
      accum_new = {work.unit_accum[23:0], b};
      lit_left  = work.units_left - 7'd1;

      state_nxt = work;
      res_valid = 1'b0;
      res       = '0;

      if (work.phase != arle_pkg::PH_IDLE) begin
         if (depth_mode[2]) begin
            state_nxt.phase = arle_pkg::PH_IDLE;
            res_valid       = 1'b1;
            res.depth_error = 1'b1;
         end else begin
            case (work.phase)
               arle_pkg::PH_SIZE: begin
                  if (cnt_inc >= arle_pkg::SIZE_BYTES) begin
                     state_nxt.header_byte_count = 4'd0;
                     state_nxt.phase             = arle_pkg::PH_FLAGS;
                  end else begin
                     state_nxt.header_byte_count = cnt_inc;
                  end
               end
               arle_pkg::PH_FLAGS: begin
                  state_nxt.header_flags = flags_new;
                  if (cnt_inc >= arle_pkg::FLAG_BYTES) begin
                     state_nxt.header_byte_count = 4'd0;
                     if ((flags_new & arle_pkg::START_LINE_FLAG) != 16'd0) begin
                        state_nxt.phase = arle_pkg::PH_LINE;
                     end else begin
                        state_nxt.cur_y = 16'd0;
                        state_nxt.phase = arle_pkg::PH_SKIP;
                     end
                  end else begin
                     state_nxt.header_byte_count = cnt_inc;
                  end
               end
               arle_pkg::PH_LINE: begin
                  state_nxt.cur_y = {work.cur_y[7:0], b};
                  if (cnt_inc >= arle_pkg::LINE_BYTES) begin
                     state_nxt.header_byte_count = 4'd0;
                     state_nxt.phase             = arle_pkg::PH_PAD;
                  end else begin
                     state_nxt.header_byte_count = cnt_inc;
                  end
               end
               arle_pkg::PH_PAD: begin
                  if (cnt_inc >= arle_pkg::PAD_BYTES) begin
                     state_nxt.header_byte_count = 4'd0;
                     state_nxt.phase             = arle_pkg::PH_SKIP;
                  end else begin
                     state_nxt.header_byte_count = cnt_inc;
                  end
               end
               arle_pkg::PH_SKIP: begin
                  if (b == 8'd0) begin
                     state_nxt.phase = arle_pkg::PH_IDLE;
                     res_valid       = 1'b1;
                     res.frame_done  = 1'b1;
                  end else begin
                     state_nxt.cur_x = work.cur_x + skip_adv;
                     state_nxt.phase = arle_pkg::PH_CODE;
                  end
               end
               arle_pkg::PH_CODE: begin
                  state_nxt.byte_in_unit = 2'd0;
                  state_nxt.unit_accum   = 32'd0;
                  if (b == arle_pkg::CODE_NEW_SKIP) begin
                     state_nxt.phase = arle_pkg::PH_SKIP;
                  end else if (b == arle_pkg::CODE_NEXT_LINE) begin
                     state_nxt.cur_x = 16'd0;
                     state_nxt.cur_y = work.cur_y + 16'd1;
                     state_nxt.phase = arle_pkg::PH_SKIP;
                  end else if (!b[7]) begin
                     state_nxt.units_left = b[6:0];
                     state_nxt.phase      = arle_pkg::PH_LIT;
                  end else begin
                     // Negated code, 128 maps to zero.
                     state_nxt.units_left = 7'd0 - b[6:0];
                     state_nxt.phase      = arle_pkg::PH_RUN;
                  end
               end
               arle_pkg::PH_LIT, arle_pkg::PH_RUN: begin
                  if (({1'b0, work.byte_in_unit} + 3'd1)
                      < arle_pkg::unit_bytes(depth_mode[1:0])) begin
                     state_nxt.unit_accum   = accum_new;
                     state_nxt.byte_in_unit = work.byte_in_unit + 2'd1;
                  end else begin
                     res_valid      = 1'b1;
                     res.pix_x      = work.cur_x;
                     res.pix_y      = work.cur_y;
                     res.pixel_word = accum_new;
                     res.unit_width = upx;
                     if (work.phase == arle_pkg::PH_LIT) begin
                        res.repeat_count     = 7'd1;
                        state_nxt.cur_x      = work.cur_x + {13'd0, upx};
                        state_nxt.units_left = lit_left;
                        if (lit_left == 7'd0) begin
                           state_nxt.phase = arle_pkg::PH_CODE;
                        end
                     end else begin
                        res.repeat_count     = work.units_left;
                        state_nxt.cur_x      = work.cur_x + run_adv;
                        state_nxt.units_left = 7'd0;
                        state_nxt.phase      = arle_pkg::PH_CODE;
                     end
                     state_nxt.byte_in_unit = 2'd0;
                     state_nxt.unit_accum   = 32'd0;
                  end
               end
               default: begin
                  state_nxt.phase = arle_pkg::PH_IDLE;
               end
            endcase
         end
      end
   end

endmodule
